>>> design/thc_pkg.sv
// ----------------------------------------------------------------------------
// thc_pkg
// shared types and constants of the tuple hash combiner: queue entry layout,
// item kinds, back end states and the fixed hash constants
// ----------------------------------------------------------------------------
`default_nettype none

package thc_pkg;

	localparam logic [63:0] ACC_START  = 64'h0000_0000_0034_5678;
	localparam logic [63:0] MULT_START = 64'd1000003;
	localparam logic [63:0] MULT_STEP  = 64'd82520;
	localparam logic [63:0] FINISH_ADD = 64'd97531;
	localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] EMPTY_HASH = ACC_START + FINISH_ADD;

	// cap on the count used for multiplier growth
	localparam longint unsigned MAX_ELEMENTS = 64'd65536;
	localparam logic [15:0] REM_CAP = ((MAX_ELEMENTS - 64'd1) >= 64'd65535) ?
		16'hFFFF : 16'(MAX_ELEMENTS - 64'd1);

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		K_FOLD  = 2'd0,
		K_ERROR = 2'd1,
		K_EMPTY = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] hash;
		logic [63:0] mult;
		logic        last;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	typedef enum logic {
		BK_TAKE = 1'b0,
		BK_SUM  = 1'b1
	} back_state_t;

endpackage

`default_nettype wire

>>> design/thc_front.sv
// ----------------------------------------------------------------------------
// thc_front
// accepts element items, tracks tuple skipping and the multiplier sequence,
// and pushes classified work into the queue
// ----------------------------------------------------------------------------
`default_nettype none

module thc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic            op,
	input  wire logic [63:0]     element_hash,
	input  wire logic [15:0]     remaining,
	output logic                 push,
	output thc_pkg::entry_t      entry
);

	logic [63:0] mult_q;
	logic        skipping_q;
	logic [63:0] mult_d;
	logic        skipping_d;
	logic [15:0] rem_c;
	logic        last;

	assign last  = (remaining == 16'd0);
	assign rem_c = (remaining > thc_pkg::REM_CAP) ? thc_pkg::REM_CAP : remaining;

	always_comb begin
		push        = 1'b0;
		entry.kind  = thc_pkg::K_FOLD;
		entry.hash  = element_hash;
		entry.mult  = mult_q;
		entry.last  = last;
		mult_d      = mult_q;
		skipping_d  = skipping_q;
		if (op) begin
			push       = accept;
			entry.kind = thc_pkg::K_EMPTY;
			mult_d     = thc_pkg::MULT_START;
			skipping_d = 1'b0;
		end else if (skipping_q) begin
			// rest of a failed tuple is dropped here
			if (last) begin
				skipping_d = 1'b0;
				mult_d     = thc_pkg::MULT_START;
			end
		end else if (element_hash == thc_pkg::ALL_ONES) begin
			push       = accept;
			entry.kind = thc_pkg::K_ERROR;
			mult_d     = thc_pkg::MULT_START;
			skipping_d = !last;
		end else begin
			push = accept;
			if (last) begin
				mult_d = thc_pkg::MULT_START;
			end else begin
				mult_d = mult_q + thc_pkg::MULT_STEP + 64'({rem_c, 1'b0});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q     <= thc_pkg::MULT_START;
			skipping_q <= 1'b0;
		end else if (accept) begin
			mult_q     <= mult_d;
			skipping_q <= skipping_d;
		end
	end

endmodule

`default_nettype wire

>>> design/thc_queue.sv
// ----------------------------------------------------------------------------
// thc_queue
// short register queue between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module thc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire thc_pkg::entry_t wr_entry,
	input  wire logic            pop,
	output thc_pkg::entry_t      head,
	output thc_pkg::qstat_t      stat
);

	thc_pkg::entry_t               mem_q [thc_pkg::QDEPTH];
	logic [thc_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [thc_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [thc_pkg::QPTR_W:0]      count_q;
	logic                          do_push;
	logic                          do_pop;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (thc_pkg::QPTR_W + 1)'(thc_pkg::QDEPTH));
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/thc_back.sv
// ----------------------------------------------------------------------------
// thc_back
// owns the accumulator: folds elements with a split 64-bit multiply whose partial
// products are registered, finishes tuples and drives the output register
// ----------------------------------------------------------------------------
`default_nettype none

module thc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire thc_pkg::entry_t head,
	input  wire thc_pkg::qstat_t qstat,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [63:0]          m_tdata,
	output logic                 m_tuser
);

	thc_pkg::back_state_t state_q, state_d;

	logic [63:0] acc_q;
	logic [63:0] acc_d;
	logic        acc_load;

	logic [63:0] p_lo_s1;
	logic [31:0] p_a_s1;
	logic [31:0] p_b_s1;
	logic        last_s1;
	logic        s1_load;

	logic [63:0] xv;
	logic [63:0] prod_a;
	logic [63:0] prod_b;
	logic [63:0] sum;
	logic [63:0] fin;

	logic        out_free;
	logic        out_load;
	logic [63:0] out_hash;
	logic        out_failed;

	assign out_free = !m_tvalid || m_tready;

	// low 64 bits of the product from three 32x32 partial products
	assign xv     = acc_q ^ head.hash;
	assign prod_a = xv[31:0] * head.mult[63:32];
	assign prod_b = xv[63:32] * head.mult[31:0];
	assign sum    = p_lo_s1 + {p_a_s1 + p_b_s1, 32'h0};

	always_comb begin
		fin = sum + thc_pkg::FINISH_ADD;
		if (fin == thc_pkg::ALL_ONES) begin
			fin = thc_pkg::ALL_ONES - 64'd1;
		end
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		s1_load    = 1'b0;
		acc_load   = 1'b0;
		acc_d      = thc_pkg::ACC_START;
		out_load   = 1'b0;
		out_hash   = fin;
		out_failed = 1'b0;
		unique case (state_q)
			thc_pkg::BK_TAKE: begin
				if (!qstat.empty) begin
					unique case (head.kind)
						thc_pkg::K_FOLD: begin
							pop     = 1'b1;
							s1_load = 1'b1;
							state_d = thc_pkg::BK_SUM;
						end
						thc_pkg::K_ERROR: begin
							if (out_free) begin
								pop        = 1'b1;
								acc_load   = 1'b1;
								out_load   = 1'b1;
								out_hash   = thc_pkg::ALL_ONES;
								out_failed = 1'b1;
							end
						end
						thc_pkg::K_EMPTY: begin
							if (out_free) begin
								pop      = 1'b1;
								acc_load = 1'b1;
								out_load = 1'b1;
								out_hash = thc_pkg::EMPTY_HASH;
							end
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			thc_pkg::BK_SUM: begin
				if (!last_s1) begin
					acc_load = 1'b1;
					acc_d    = sum;
					state_d  = thc_pkg::BK_TAKE;
				end else if (out_free) begin
					acc_load = 1'b1;
					out_load = 1'b1;
					state_d  = thc_pkg::BK_TAKE;
				end
			end
			default: begin
				state_d = thc_pkg::BK_TAKE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= thc_pkg::BK_TAKE;
			acc_q    <= thc_pkg::ACC_START;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc_load) begin
				acc_q <= acc_d;
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			p_lo_s1 <= xv[31:0] * head.mult[31:0];
			p_a_s1  <= prod_a[31:0];
			p_b_s1  <= prod_b[31:0];
			last_s1 <= head.last;
		end
		if (out_load) begin
			m_tdata <= out_hash;
			m_tuser <= out_failed;
		end
	end

endmodule

`default_nettype wire

>>> design/tuple_hash_combiner.sv
// ----------------------------------------------------------------------------
// tuple_hash_combiner
// folds a stream of 64-bit element hashes into 64-bit tuple hashes
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  s_*      | in        | one element or one empty-tuple marker
//  m_*      | out       | one finished tuple hash or an error flag
//
//  the front end takes one transaction per cycle while the 4-entry queue has room
//  a folded element goes through BK_TAKE (xor, registered partial products), then
//  BK_SUM (sum into the accumulator, or the finished hash out on a free output);
//  error and empty-tuple items use only BK_TAKE; elements of a skipped tuple are
//  dropped by the front end and never queued; reset is asynchronous and needs no
//  clearing pass; a stalled m side fills the queue and only then drops s_tready
// ----------------------------------------------------------------------------
`default_nettype none

module tuple_hash_combiner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // element_hash[63:0], remaining[79:64]
	input  wire logic        s_tuser,   // op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // tuple_hash[63:0]
	output logic             m_tuser    // failed
);

	logic            accept;
	logic            push;
	logic            pop;
	thc_pkg::entry_t wr_entry;
	thc_pkg::entry_t head;
	thc_pkg::qstat_t qstat;

	assign s_tready = !qstat.full;
	assign accept   = s_tvalid && s_tready;

	thc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.op           (s_tuser),
		.element_hash (s_tdata[63:0]),
		.remaining    (s_tdata[79:64]),
		.push         (push),
		.entry        (wr_entry)
	);

	thc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	thc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// error results always carry the all-ones hash
	a_error_hash: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == thc_pkg::ALL_ONES)
		else $error("error result without all-ones hash");

	// a good result never collides with the error value
	a_good_hash: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata != thc_pkg::ALL_ONES)
		else $error("finished hash equals the error value");

	// back end never pulls from an empty queue
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	// front end never pushes into a full queue
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for tuple_hash_combiner: directed tuples, error and
// skip sequences, then random tuple streams with random idles on both sides
// and one long output stall; every result is matched against a bit-exact
// software fold of the same stream
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam bit OP_ELEMENT = 1'b0;
	localparam bit OP_EMPTY   = 1'b1;
	localparam int unsigned RANDOM_ITEMS = 550;
	localparam int unsigned STALL_AT     = 60;
	localparam int unsigned STALL_CYCLES = 300;

	typedef struct packed {
		logic [63:0] hash;
		logic        failed;
	} hash_result_t;

	class tuple_hash_scoreboard;
		logic [63:0]  acc;
		logic [63:0]  mult;
		bit           skipping;
		hash_result_t expected_hashes[$];
		int unsigned  mismatches;

		function new();
			restart();
			skipping = 1'b0;
			mismatches = 0;
		endfunction

		function void restart();
			acc = thc_pkg::ACC_START;
			mult = thc_pkg::MULT_START;
		endfunction

		function logic [63:0] finish_hash(logic [63:0] x);
			logic [63:0] y;
			y = x + thc_pkg::FINISH_ADD;
			return (y == thc_pkg::ALL_ONES) ? thc_pkg::ALL_ONES - 64'd1 : y;
		endfunction

		// returns 1 when the block just drops the transaction
		function bit fold_item(bit op, logic [63:0] h, logic [15:0] rem);
			logic [15:0] grow;
			if (op == OP_EMPTY) begin
				restart();
				skipping = 1'b0;
				expected_hashes.push_back('{finish_hash(thc_pkg::ACC_START), 1'b0});
				return 1'b0;
			end
			if (skipping) begin
				if (rem == 16'd0) begin
					skipping = 1'b0;
					restart();
				end
				return 1'b1;
			end
			if (h == thc_pkg::ALL_ONES) begin
				restart();
				skipping = (rem != 16'd0);
				expected_hashes.push_back('{thc_pkg::ALL_ONES, 1'b1});
				return 1'b0;
			end
			acc = (acc ^ h) * mult;
			grow = (rem > thc_pkg::REM_CAP) ? thc_pkg::REM_CAP : rem;
			mult = mult + thc_pkg::MULT_STEP + 64'(grow) + 64'(grow);
			if (rem == 16'd0) begin
				expected_hashes.push_back('{finish_hash(acc), 1'b0});
				restart();
			end
			return 1'b0;
		endfunction

		function void check_hash(logic [63:0] hash, logic failed);
			hash_result_t exp_r;
			if (expected_hashes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: hash %h failed %b", hash, failed);
				return;
			end
			exp_r = expected_hashes.pop_front();
			if (hash !== exp_r.hash || failed !== exp_r.failed) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: hash exp %h got %h, failed exp %b got %b",
						exp_r.hash, hash, exp_r.failed, failed);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;   // element_hash[63:0], remaining[79:64]
	logic        s_tuser = 1'b0; // op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // tuple_hash[63:0]
	logic        m_tuser;        // failed

	tuple_hash_scoreboard board = new();
	int unsigned items_counted = 0;
	int unsigned results_seen = 0;
	int unsigned tx_quiet = 0;
	int unsigned rx_quiet = 0;

	tuple_hash_combiner uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial forever #2 clk = ~clk;

	// idle cycles before the next transaction, with runs of back-to-back ones
	function automatic int unsigned idle_draw(inout int unsigned quiet);
		if (quiet != 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0) begin
			quiet = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction

	function automatic logic [63:0] random_hash();
		int unsigned pick;
		pick = $urandom_range(0, 79);
		if (pick < 2)
			return thc_pkg::ALL_ONES;
		if (pick < 4)
			return 64'd0;
		if (pick < 5)
			return thc_pkg::ALL_ONES - 64'd1;
		return {$urandom, $urandom};
	endfunction

	task automatic send_item(bit op, logic [63:0] h, logic [15:0] rem);
		int unsigned gap;
		gap = idle_draw(tx_quiet);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= 80'({$urandom, $urandom, $urandom});
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {rem, h};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		if (!board.fold_item(op, h, rem))
			items_counted++;
	endtask

	// output side: random back-pressure plus one long stall
	initial begin
		int unsigned gap;
		bit stalled;
		stalled = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = idle_draw(rx_quiet);
			if (!stalled && results_seen >= STALL_AT) begin
				stalled = 1'b1;
				gap = STALL_CYCLES;
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.check_hash(m_tdata, m_tuser);
			results_seen++;
		end
	end

	initial begin
		logic [63:0] inv;
		int unsigned len;
		int unsigned sel;
		bit broken;
		logic [15:0] rem;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tuple with junk fields, single-element tuples at the extremes, a three-element tuple
		send_item(OP_EMPTY, thc_pkg::ALL_ONES, 16'hFFFF);
		send_item(OP_ELEMENT, 64'd0, 16'd0);
		send_item(OP_ELEMENT, thc_pkg::ALL_ONES - 64'd1, 16'd0);
		send_item(OP_ELEMENT, 64'h8000_0000_0000_0000, 16'd2);
		send_item(OP_ELEMENT, 64'h0123_4567_89AB_CDEF, 16'd1);
		send_item(OP_ELEMENT, 64'd1, 16'd0);
		// error on a lone last element: no skipping afterwards
		send_item(OP_ELEMENT, thc_pkg::ALL_ONES, 16'd0);
		// error mid tuple, the last element of the skipped tuple is not examined
		send_item(OP_ELEMENT, 64'd5, 16'd2);
		send_item(OP_ELEMENT, thc_pkg::ALL_ONES, 16'd1);
		send_item(OP_ELEMENT, thc_pkg::ALL_ONES, 16'd0);
		send_item(OP_ELEMENT, thc_pkg::ALL_ONES, 16'hFFFF);
		send_item(OP_ELEMENT, 64'd7, 16'hFFFF);
		send_item(OP_ELEMENT, 64'd9, 16'd0);
		// empty tuple abandons a partial tuple and a skip
		send_item(OP_ELEMENT, 64'd3, 16'd3);
		send_item(OP_EMPTY, 64'd0, 16'd0);
		send_item(OP_ELEMENT, thc_pkg::ALL_ONES, 16'd2);
		send_item(OP_EMPTY, {$urandom, $urandom}, 16'(($urandom)));
		send_item(OP_ELEMENT, 64'd11, 16'd0);
		// counts that do not count down, largest growth step
		send_item(OP_ELEMENT, 64'd22, 16'hFFFF);
		send_item(OP_ELEMENT, 64'd33, 16'd7);
		send_item(OP_ELEMENT, 64'd44, 16'd0);
		// hash chosen so that the finished sum lands on all ones
		inv = thc_pkg::MULT_START;
		repeat (6) inv = inv * (64'd2 - thc_pkg::MULT_START * inv);
		send_item(OP_ELEMENT, thc_pkg::ACC_START ^
			((thc_pkg::ALL_ONES - thc_pkg::FINISH_ADD) * inv), 16'd0);

		items_counted = 0;
		while (items_counted < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				send_item(OP_EMPTY, {$urandom, $urandom}, 16'($urandom));
			end else if (sel < 14) begin
				send_item(OP_ELEMENT, random_hash(), 16'($urandom));
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) :
					$urandom_range(1, 6);
				broken = ($urandom_range(0, 9) == 0);
				for (int unsigned i = 0; i < len; i++) begin
					rem = 16'(len - 1 - i);
					if (broken && $urandom_range(0, 2) == 0)
						rem = 16'($urandom_range(0, 65535));
					send_item(OP_ELEMENT, random_hash(), rem);
				end
			end
		end
		s_tvalid <= 1'b0;

		while (board.expected_hashes.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.mismatches == 0 && board.expected_hashes.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
